// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL. Defining ASSERT_OFF removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("Assertion failed: implication does not hold.");

`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("Assertion failed: next-cycle implication does not hold.");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)

`define ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// ===== design/ev1527_pkg.sv =====
`default_nettype none

package ev1527_pkg;

    localparam int CODE_BITS = 24;
    localparam int CNT_W     = $clog2(CODE_BITS + 1);
    localparam int TIME_W    = 15;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = ((CODE_BITS + 1 + 7) / 8) * 8;

    localparam logic [TIME_W-1:0] SHORT_MIN_RST = 15'd234;
    localparam logic [TIME_W-1:0] SHORT_MAX_RST = 15'd466;
    localparam logic [TIME_W-1:0] LONG_MIN_RST  = 15'd702;
    localparam logic [TIME_W-1:0] LONG_MAX_RST  = 15'd1398;
    localparam logic [TIME_W-1:0] SYNC_MIN_RST  = 15'd8750;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_MIN = 3'd0,
        CFG_SHORT_MAX = 3'd1,
        CFG_LONG_MIN  = 3'd2,
        CFG_LONG_MAX  = 3'd3,
        CFG_SYNC_MIN  = 3'd4
    } cfg_idx_t;

    // A symbol after classification, as it waits in the queue.
    typedef struct packed {
        logic first_level;
        logic is_short;
        logic is_long;
        logic is_sync;
        logic burst_end;
    } sym_t;

endpackage

`default_nettype wire

// ===== design/ev1527_classify.sv =====
`default_nettype none

module ev1527_classify
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [ev1527_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ev1527_pkg::TIME_W-1:0]     cfg_data,
    input  wire logic                              first_level,
    input  wire logic [ev1527_pkg::TIME_W-1:0]     first_time,
    input  wire logic                              second_level,
    input  wire logic [ev1527_pkg::TIME_W-1:0]     second_time,
    input  wire logic                              burst_end,
    output ev1527_pkg::sym_t                       sym
);
    import ev1527_pkg::*;

    logic [TIME_W-1:0] short_min_reg, short_max_reg, long_min_reg, long_max_reg, sync_min_reg;
    logic              first_bad, second_bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_min_reg <= SHORT_MIN_RST;
            short_max_reg <= SHORT_MAX_RST;
            long_min_reg  <= LONG_MIN_RST;
            long_max_reg  <= LONG_MAX_RST;
            sync_min_reg  <= SYNC_MIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SHORT_MIN: short_min_reg <= cfg_data;
                CFG_SHORT_MAX: short_max_reg <= cfg_data;
                CFG_LONG_MIN:  long_min_reg  <= cfg_data;
                CFG_LONG_MAX:  long_max_reg  <= cfg_data;
                CFG_SYNC_MIN:  sync_min_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        first_bad  = !first_level && (first_time < sync_min_reg);
        second_bad = !second_level && (second_time < sync_min_reg);
        sym.first_level = first_level;
        sym.is_short    = (first_time >= short_min_reg) && (first_time <= short_max_reg);
        sym.is_long     = (first_time >= long_min_reg) && (first_time <= long_max_reg);
        sym.is_sync     = !first_bad && !second_bad;
        sym.burst_end   = burst_end;
    end

endmodule

`default_nettype wire

// ===== design/ev1527_queue.sv =====
`default_nettype none

module ev1527_queue
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire ev1527_pkg::sym_t push_data,
    output logic             not_full,
    input  wire logic        pop,
    output logic             not_empty,
    output ev1527_pkg::sym_t head
);
    import ev1527_pkg::*;

    sym_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    always_comb
    begin
        not_full  = (count_reg != 2'd2);
        not_empty = (count_reg != 2'd0);
        head      = entry_reg[rd_ptr_reg];
        do_push   = push && not_full;
        do_pop    = pop && not_empty;
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/ev1527_frame.sv =====
`default_nettype none

module ev1527_frame
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               sym_valid,
    input  wire ev1527_pkg::sym_t                   sym,
    output logic                                    sym_pop,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [ev1527_pkg::CODE_BITS-1:0]        out_code,
    output logic                                    out_status
);
    import ev1527_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_COLLECT = 3'b010,
        PH_DONE    = 3'b100
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [CODE_BITS-1:0]  code_reg, code_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      cnt_inc;
    logic                  out_valid_reg, out_valid_next;
    logic [CODE_BITS-1:0]  out_code_reg, out_code_next;
    logic                  out_status_reg, out_status_next;
    logic                  bit_val, bit_ok, hunt_check, emit;

    always_comb
    begin
        sym_pop    = sym_valid && (!out_valid_reg || out_ready);
        bit_ok     = sym.is_short || sym.is_long;
        bit_val    = sym.is_short ? !sym.first_level : sym.first_level;
        cnt_inc    = cnt_reg + CNT_W'(1);
        phase_next = phase_reg;
        code_next  = code_reg;
        cnt_next   = cnt_reg;
        hunt_check = 1'b0;
        emit       = 1'b0;
        out_code_next   = out_code_reg;
        out_status_next = out_status_reg;

        if (sym_pop)
        begin
            unique case (phase_reg)
                PH_COLLECT:
                begin
                    if (bit_ok)
                    begin
                        code_next = (code_reg << 1) | CODE_BITS'(bit_val);
                        cnt_next  = cnt_inc;
                        if (cnt_inc >= CNT_W'(CODE_BITS))
                        begin
                            emit            = 1'b1;
                            out_code_next   = code_next;
                            out_status_next = 1'b0;
                            phase_next      = PH_DONE;
                        end
                    end
                    else
                    begin
                        // A bad bit drops the partial code; the symbol may still be a sync.
                        phase_next = PH_HUNT;
                        code_next  = '0;
                        cnt_next   = '0;
                        hunt_check = 1'b1;
                    end
                end
                PH_DONE: ;
                default: hunt_check = 1'b1;
            endcase

            if (hunt_check && sym.is_sync)
            begin
                phase_next = PH_COLLECT;
                code_next  = '0;
                cnt_next   = '0;
            end

            if (sym.burst_end)
            begin
                if (phase_next != PH_DONE)
                begin
                    emit            = 1'b1;
                    out_code_next   = '0;
                    out_status_next = 1'b1;
                end
                phase_next = PH_HUNT;
                code_next  = '0;
                cnt_next   = '0;
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        out_valid  = out_valid_reg;
        out_code   = out_code_reg;
        out_status = out_status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            code_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            code_reg      <= code_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_code_reg   <= out_code_next;
        out_status_reg <= out_status_next;
    end

endmodule

`default_nettype wire

// ===== design/ev1527_pulse_width_decoder.sv =====
`default_nettype none
`include "assert_macros.svh"

// Pulse-width decoder for EV1527-style remote bursts. Each input item is one captured
// symbol; the item whose s_tlast is set closes a burst. The front classifies a symbol
// against the timing windows in the cycle it is accepted and parks it in a two-entry
// queue; the back walks the frame state and delivers at most one result per symbol
// into an output register. The block takes one symbol per cycle while its queue has
// room, and a result is presented on the master side at the edge where its symbol
// leaves the queue. Timing registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while the block is idle; the block does not enforce it.
module ev1527_pulse_width_decoder
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [ev1527_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ev1527_pkg::TIME_W-1:0]        cfg_data,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // Fields from bit 0: first_level, first_time[14:0], second_level, second_time[14:0].
    input  wire logic [ev1527_pkg::IN_DATA_W-1:0]     s_tdata,
    input  wire logic                                 s_tlast,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // Fields from bit 0: code[23:0], status, then zero fill.
    output logic [ev1527_pkg::OUT_DATA_W-1:0]         m_tdata
);
    import ev1527_pkg::*;

    sym_t                 sym_in, sym_head;
    logic                 q_not_full, q_not_empty, q_pop;
    logic [CODE_BITS-1:0] res_code;
    logic                 res_status;

    ev1527_classify u_classify
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .first_level  (s_tdata[0]),
        .first_time   (s_tdata[15:1]),
        .second_level (s_tdata[16]),
        .second_time  (s_tdata[31:17]),
        .burst_end    (s_tlast),
        .sym          (sym_in)
    );

    ev1527_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .push_data (sym_in),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (sym_head)
    );

    ev1527_frame u_frame
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .sym_valid  (q_not_empty),
        .sym        (sym_head),
        .sym_pop    (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_code   (res_code),
        .out_status (res_status)
    );

    assign s_tready = q_not_full;
    assign m_tdata  = OUT_DATA_W'({res_status, res_code});

    `ASSERT_IMPLIES(a_status_zero_code, clk, rst_n, m_tvalid && res_status, res_code == '0)
    `ASSERT_IMPLIES(a_pop_only_when_free, clk, rst_n, q_pop, !m_tvalid || m_tready)
    `ASSERT_IMPLIES(a_stall_means_backlog, clk, rst_n, !s_tready, q_not_empty)
    `ASSERT_IMPLIES(a_pop_follows_backlog, clk, rst_n, q_not_empty && !m_tvalid, q_pop)
    `ASSERT_NEXT(a_result_held, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

`default_nettype wire

// ===== tb/tb_ev1527_pulse_width_decoder.sv =====
`timescale 1ns / 1ps

module tb_ev1527_pulse_width_decoder;

    import ev1527_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int TMAX = 32767;

    typedef struct packed {
        logic        first_level;
        logic [14:0] first_time;
        logic        second_level;
        logic [14:0] second_time;
        logic        burst_end;
    } symbol_t;

    typedef struct packed {
        logic [23:0] code;
        logic        status;
    } decode_t;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_COLLECT,
        PH_DONE
    } frame_phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIME_W-1:0]    cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    ev1527_pulse_width_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    // Timing windows as the decoder should currently hold them.
    logic [14:0] win_short_min = SHORT_MIN_RST;
    logic [14:0] win_short_max = SHORT_MAX_RST;
    logic [14:0] win_long_min  = LONG_MIN_RST;
    logic [14:0] win_long_max  = LONG_MAX_RST;
    logic [14:0] win_sync_min  = SYNC_MIN_RST;

    frame_phase_t frame_phase = PH_HUNT;
    logic [23:0]  code_acc = '0;
    int           bits_gathered = 0;

    symbol_t symbols_to_send[$];
    decode_t decodes_due[$];
    int      symbols_queued = 0;
    int      errors = 0;
    int      cycles = 0;

    function automatic bit looks_like_sync(symbol_t s);
        if (!s.first_level && s.first_time < win_sync_min)
            return 1'b0;
        if (!s.second_level && s.second_time < win_sync_min)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic void clear_frame();
        frame_phase = PH_HUNT;
        code_acc = '0;
        bits_gathered = 0;
    endfunction

    function automatic void predict_decode(symbol_t s);
        logic    bit_val;
        logic    took_bit;
        decode_t d;
        bit_val = 1'b0;
        took_bit = 1'b0;
        if (frame_phase == PH_COLLECT) begin
            if (s.first_time >= win_short_min && s.first_time <= win_short_max)
            begin
                bit_val = ~s.first_level;
                took_bit = 1'b1;
            end
            else if (s.first_time >= win_long_min && s.first_time <= win_long_max)
            begin
                bit_val = s.first_level;
                took_bit = 1'b1;
            end
            else
            begin
                clear_frame();
            end
            if (took_bit) begin
                code_acc = {code_acc[22:0], bit_val};
                bits_gathered++;
                if (bits_gathered >= CODE_BITS) begin
                    d.code = code_acc;
                    d.status = 1'b0;
                    decodes_due.push_back(d);
                    frame_phase = PH_DONE;
                end
            end
        end
        if (!took_bit && frame_phase == PH_HUNT && looks_like_sync(s)) begin
            frame_phase = PH_COLLECT;
            code_acc = '0;
            bits_gathered = 0;
        end
        if (s.burst_end) begin
            if (frame_phase != PH_DONE) begin
                d.code = '0;
                d.status = 1'b1;
                decodes_due.push_back(d);
            end
            clear_frame();
        end
    endfunction

    function automatic logic [14:0] pick_time();
        case ($urandom_range(0, 7))
            0: return 15'd0;
            1: return 15'h7fff;
            default: return 15'($urandom);
        endcase
    endfunction

    function automatic logic [14:0] time_in(int lo, int hi);
        if (lo <= hi)
            return 15'($urandom_range(hi, lo));
        return pick_time();
    endfunction

    function automatic void add_symbol(logic fl, logic [14:0] ft, logic sl,
                                       logic [14:0] st, logic be);
        symbol_t s;
        s.first_level = fl;
        s.first_time = ft;
        s.second_level = sl;
        s.second_time = st;
        s.burst_end = be;
        symbols_to_send.push_back(s);
        symbols_queued++;
    endfunction

    function automatic void add_any(logic be);
        add_symbol(1'($urandom), pick_time(), 1'($urandom), pick_time(), be);
    endfunction

    function automatic void add_sync();
        logic        fl;
        logic        sl;
        logic [14:0] ft;
        logic [14:0] st;
        fl = 1'($urandom);
        sl = 1'($urandom);
        ft = fl ? pick_time() : time_in(win_sync_min, TMAX);
        st = sl ? pick_time() : time_in(win_sync_min, TMAX);
        add_symbol(fl, ft, sl, st, 1'b0);
    endfunction

    function automatic void add_non_sync(logic be);
        if (win_sync_min == 0)
            add_any(be);
        else
            add_symbol(1'b0, time_in(0, win_sync_min - 1), 1'($urandom), pick_time(), be);
    endfunction

    function automatic void add_bit(logic be);
        logic        use_short;
        logic [14:0] ft;
        use_short = 1'($urandom);
        if (win_short_min > win_short_max)
            use_short = 1'b0;
        if (win_long_min > win_long_max && win_short_min <= win_short_max)
            use_short = 1'b1;
        ft = use_short ? time_in(win_short_min, win_short_max)
                       : time_in(win_long_min, win_long_max);
        add_symbol(1'($urandom), ft, 1'($urandom), pick_time(), be);
    endfunction

    function automatic void add_bad_bit();
        logic [14:0] ft;
        ft = pick_time();
        for (int i = 0; i < 8; i++) begin
            if ((ft >= win_short_min && ft <= win_short_max) ||
                (ft >= win_long_min && ft <= win_long_max))
                ft = 15'($urandom);
        end
        add_symbol(1'($urandom), ft, 1'($urandom), pick_time(), 1'b0);
    endfunction

    function automatic void add_burst();
        int kind;
        int extra;
        int n;
        kind = $urandom_range(0, 19);
        if (kind < 12) begin
            n = $urandom_range(0, 2);
            for (int i = 0; i < n; i++)
                add_non_sync(1'b0);
            add_sync();
            extra = $urandom_range(0, 3);
            for (int i = 0; i < CODE_BITS; i++)
                add_bit(i == CODE_BITS - 1 && extra == 0);
            for (int i = 0; i < extra; i++)
                add_any(i == extra - 1);
        end
        else if (kind < 15) begin
            add_sync();
            n = $urandom_range(0, 23);
            for (int i = 0; i < n; i++)
                add_bit(1'b0);
            add_bad_bit();
            if ($urandom_range(0, 1))
                add_sync();
            n = $urandom_range(0, 26);
            for (int i = 0; i < n; i++)
                add_bit(1'b0);
            add_any(1'b1);
        end
        else if (kind < 17) begin
            add_sync();
            n = $urandom_range(0, 22);
            for (int i = 0; i < n; i++)
                add_bit(1'b0);
            add_bit(1'b1);
        end
        else
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                add_any(i == n - 1 || $urandom_range(0, 7) == 0);
        end
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [14:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_SHORT_MIN: win_short_min = value;
            CFG_SHORT_MAX: win_short_max = value;
            CFG_LONG_MIN:  win_long_min = value;
            CFG_LONG_MAX:  win_long_max = value;
            CFG_SYNC_MIN:  win_sync_min = value;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (symbols_to_send.size() != 0 || s_tvalid || decodes_due.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic run_phase(int s_lo, int s_hi, int l_lo, int l_hi, int sync_lo,
                             int n_items);
        int start;
        wait_idle();
        write_reg(CFG_SHORT_MIN, 15'(s_lo));
        write_reg(CFG_SHORT_MAX, 15'(s_hi));
        write_reg(CFG_LONG_MIN, 15'(l_lo));
        write_reg(CFG_LONG_MAX, 15'(l_hi));
        write_reg(CFG_SYNC_MIN, 15'(sync_lo));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        start = symbols_queued;
        while (symbols_queued - start < n_items)
            add_burst();
    endtask

    // Sender: bursts of random length with random gaps.
    symbol_t on_bus;
    int      burst_left = 0;
    int      gap_left = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                predict_decode(on_bus);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || symbols_to_send.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    on_bus = symbols_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {on_bus.second_time, on_bus.second_level,
                                on_bus.first_time, on_bus.first_level};
                    s_tlast <= on_bus.burst_end;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // Receiver: changes its stall pattern now and then, and holds off for a long
    // stretch at a few points so that the decoder backs up into its input.
    int rx_tick = 0;
    int rx_mode = 0;
    int rx_taken = 0;
    int hold_left = 0;
    int next_hold_mark = 10;

    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready)
                rx_taken++;
            rx_tick++;
            if (rx_tick % 97 == 0)
                rx_mode = $urandom_range(0, 2);
            if (hold_left == 0 && rx_taken >= next_hold_mark) begin
                hold_left = 300;
                next_hold_mark = next_hold_mark * 6;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom);
                    default: m_tready <= (rx_tick % 3 == 0);
                endcase
            end
        end
    end

    decode_t oldest_decode;

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (decodes_due.size() == 0) begin
                $error("result with none expected: code %h status %0d",
                       m_tdata[23:0], m_tdata[24]);
                errors++;
            end
            else
            begin
                oldest_decode = decodes_due.pop_front();
                if (m_tdata[23:0] !== oldest_decode.code) begin
                    $error("code: expected %h, actual %h", oldest_decode.code, m_tdata[23:0]);
                    errors++;
                end
                if (m_tdata[24] !== oldest_decode.status) begin
                    $error("status: expected %0d, actual %0d",
                           oldest_decode.status, m_tdata[24]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int s_lo;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        run_phase(SHORT_MIN_RST, SHORT_MAX_RST, LONG_MIN_RST, LONG_MAX_RST,
                  SYNC_MIN_RST, 0);
        add_symbol(1'b0, 15'd8749, 1'b1, 15'd0, 1'b1);
        add_symbol(1'b0, 15'd8750, 1'b0, 15'd8750, 1'b0);
        add_symbol(1'b1, 15'd0, 1'b1, 15'd0, 1'b1);
        add_symbol(1'b1, 15'h7fff, 1'b0, 15'h7fff, 1'b0);
        for (int i = 0; i < CODE_BITS; i++) begin
            case (i % 4)
                0: add_symbol(1'(i), SHORT_MIN_RST, 1'(i / 2), 15'h7fff, i == CODE_BITS - 1);
                1: add_symbol(1'(i), SHORT_MAX_RST, 1'(i / 2), 15'd0, i == CODE_BITS - 1);
                2: add_symbol(1'(i), LONG_MIN_RST, 1'(i / 2), 15'd0, i == CODE_BITS - 1);
                default: add_symbol(1'(i), LONG_MAX_RST, 1'(i / 2), 15'h7fff,
                                    i == CODE_BITS - 1);
            endcase
        end
        for (int i = 0; i < 160; )
        begin
            add_burst();
            i = symbols_queued - 28;
        end

        run_phase(0, 0, 1, TMAX, 0, 150);
        run_phase(100, 900, 500, 1500, TMAX, 150);
        run_phase(600, 500, 0, TMAX, $urandom_range(0, TMAX), 120);
        run_phase(TMAX, TMAX, 0, TMAX - 1, 1, 100);
        for (int p = 0; p < 3; p++) begin
            s_lo = $urandom_range(0, 2000);
            run_phase(s_lo, s_lo + $urandom_range(0, 800), $urandom_range(1500, 3000),
                      $urandom_range(2500, 6000), $urandom_range(0, TMAX), 80);
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (decodes_due.size() != 0) begin
            $error("expected results never arrived: %0d", decodes_due.size());
            errors++;
        end
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
